// ===== rtl/ldm_pkg.sv =====
`default_nettype none
package ldm_pkg;

	localparam int FRAC      = 16;
	localparam int IDX_W     = 12;
	localparam int GRID_W    = 13;
	localparam int WORD_W    = 32;
	localparam int MAG_W     = 26;
	localparam int REG_IDX_W = 3;

	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(512);
	// smallest divisor for the magnification, round(0.001 * 2^FRAC)
	localparam int                J_FLOOR    = ((1 << FRAC) + 500) / 1000;
	localparam logic [MAG_W-1:0]  MAG_CAP    = MAG_W'(1000 << FRAC);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HOLE_X,
		REG_HOLE_Y,
		REG_HOLE_Z,
		REG_CAMERA_X,
		REG_CAMERA_Y,
		REG_CAMERA_Z,
		REG_LENS_STRENGTH,
		REG_GRID_SIZE
	} ldm_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} ldm_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] deflect_x;
		logic signed [WORD_W-1:0] deflect_y;
		logic [MAG_W-1:0]         magnification;
	} ldm_out_t;

endpackage
`default_nettype wire

// ===== rtl/ldm_delay.sv =====
`default_nettype none
module ldm_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/ldm_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage, NL lanes sharing one divisor.
// Each numerator must be below den << QW.
module ldm_div #(
	parameter int NL = 1,
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [NL-1:0][NW-1:0]  num,
	input  logic [DW-1:0]          den,
	output logic                   out_valid,
	output logic [NL-1:0][QW-1:0]  quo
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic                  vld_s [QW];
	logic [DW-1:0]         den_s [QW];
	logic [NL-1:0][NW-1:0] rem_s [QW];
	logic [NL-1:0][QW-1:0] quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic                  v_in;
		logic [DW-1:0]         d_in;
		logic [NL-1:0][NW-1:0] r_in;
		logic [NL-1:0][NW-1:0] r_nx;
		logic [NL-1:0][QW-1:0] q_in;
		logic [NL-1:0][QW-1:0] q_nx;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign d_in = den;
			assign r_in = num;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign d_in = den_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = quo_s[i-1];
		end

		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [CW-1:0] r_ext;
			logic [CW-1:0] d_sh;
			logic          ge;
			assign r_ext   = CW'(r_in[l]);
			assign d_sh    = CW'(d_in) << (QW - 1 - i);
			assign ge      = r_ext >= d_sh;
			assign r_nx[l] = ge ? NW'(r_ext - d_sh) : r_in[l];
			assign q_nx[l] = q_in[l] | (QW'(ge) << (QW - 1 - i));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= d_in;
				rem_s[i] <= r_nx;
				quo_s[i] <= q_nx;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];

endmodule
`default_nettype wire

// ===== rtl/ldm_sqrt.sv =====
`default_nettype none
// Floor square root, one result bit per stage, NL independent lanes.
module ldm_sqrt #(
	parameter int NL = 1,
	parameter int IW = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [NL-1:0][IW-1:0]    rad,
	output logic                     out_valid,
	output logic [NL-1:0][IW/2-1:0]  root
);

	localparam int OW = IW / 2;

	logic                  vld_s [OW];
	logic [NL-1:0][IW-1:0] val_s [OW];
	logic [NL-1:0][IW-1:0] res_s [OW];

	for (genvar i = 0; i < OW; i++) begin : g_stage
		logic                  v_in;
		logic [NL-1:0][IW-1:0] val_in;
		logic [NL-1:0][IW-1:0] res_in;
		logic [NL-1:0][IW-1:0] val_nx;
		logic [NL-1:0][IW-1:0] res_nx;
		logic [IW-1:0]         bitc;

		assign bitc = IW'(1) << (2 * (OW - 1 - i));

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign val_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign v_in   = vld_s[i-1];
			assign val_in = val_s[i-1];
			assign res_in = res_s[i-1];
		end

		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [IW:0] trial;
			logic        ge;
			assign trial     = {1'b0, res_in[l]} + {1'b0, bitc};
			assign ge        = {1'b0, val_in[l]} >= trial;
			assign val_nx[l] = ge ? IW'({1'b0, val_in[l]} - trial) : val_in[l];
			assign res_nx[l] = ge ? (res_in[l] >> 1) + bitc : res_in[l] >> 1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[i] <= val_nx;
				res_s[i] <= res_nx;
			end
		end
	end

	assign out_valid = vld_s[OW-1];
	for (genvar l = 0; l < NL; l++) begin : g_out
		assign root[l] = res_s[OW-1][l][OW-1:0];
	end

endmodule
`default_nettype wire

// ===== rtl/lensing_deflection_map.sv =====
// Point-mass lensing map: one grid point in, one deflection and magnification out.
// Input channel in_valid/in_ready/in_item carries the grid row and column; the
// output channel out_valid/out_ready/out_item carries deflect_x, deflect_y
// (signed Q16.16, saturated) and magnification (unsigned Q10.16, at most 1000).
// The write port (wr_en, wr_index, wr_data) sets hole and camera positions,
// lens strength and grid size; write it only while no point is in flight.
// From transfer in to result valid, a point passes the chain of
// bit-per-stage dividers (29, 17, 48, 32 and 26 stages) and square roots
// (30 and 32 stages) plus 16 arithmetic and output stages.
// Throughput is one point per cycle while the receiver does not stall; every stage holds one point.
// Reset clears all valid bits and sets the registers to zero, grid size 512.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module lensing_deflection_map
	import ldm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ldm_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ldm_out_t             out_item,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data
);

	localparam int SCR_W  = IDX_W + FRAC + 1;
	localparam int SX_W   = SCR_W + 2;
	localparam int SS_W   = 2 * SCR_W + 2;
	localparam int LEN_W  = SS_W / 2;
	localparam int U_QW   = FRAC + 1;
	localparam int U_NW   = SCR_W + FRAC;
	localparam int U_W    = U_QW + 1;
	localparam int T_W    = WORD_W + 1;
	localparam int DOT_W  = T_W + U_W;
	localparam int SUM_W  = DOT_W + 2;
	localparam int TT_W   = SUM_W - FRAC;
	localparam int M_W    = U_W + TT_W;
	localparam int D_W    = M_W - FRAC + 1;
	localparam int P_W    = 2 * WORD_W;
	localparam int IMP_W  = P_W / 2;
	localparam int MAG_QW = WORD_W + FRAC;
	localparam int HALF   = MAG_QW / 2;
	localparam int PP_W   = HALF + WORD_W;
	localparam int PR_W   = MAG_QW + WORD_W;
	localparam int J_W    = WORD_W + 2;
	localparam int AMP_NW = 2 * FRAC + 1;

	// configuration registers
	logic signed [WORD_W-1:0] hole_q [3];
	logic signed [WORD_W-1:0] camera_q [3];
	logic [WORD_W-1:0]        strength_q;
	logic [GRID_W-1:0]        grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				hole_q[k]   <= '0;
				camera_q[k] <= '0;
			end
			strength_q <= '0;
			grid_q     <= GRID_RESET;
		end else if (wr_en) begin
			case (ldm_reg_t'(wr_index))
				REG_HOLE_X:        hole_q[0]   <= wr_data;
				REG_HOLE_Y:        hole_q[1]   <= wr_data;
				REG_HOLE_Z:        hole_q[2]   <= wr_data;
				REG_CAMERA_X:      camera_q[0] <= wr_data;
				REG_CAMERA_Y:      camera_q[1] <= wr_data;
				REG_CAMERA_Z:      camera_q[2] <= wr_data;
				REG_LENS_STRENGTH: strength_q  <= wr_data;
				REG_GRID_SIZE:     grid_q      <= wr_data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	logic              en;
	logic [GRID_W-1:0] n;
	logic signed [T_W-1:0] tv [3];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign n        = (grid_q == '0) ? GRID_W'(1) : grid_q;

	for (genvar k = 0; k < 3; k++) begin : g_delta
		assign tv[k] = $signed({hole_q[k][WORD_W-1], hole_q[k]})
			- $signed({camera_q[k][WORD_W-1], camera_q[k]});
	end

	// screen coordinates: 2*idx*2^F / N
	logic                     scr_v;
	logic [1:0][SCR_W-1:0]    scr_q;

	ldm_div #(.NL(2), .NW(SCR_W), .DW(GRID_W), .QW(SCR_W)) u_scr (
		.clk, .arst_n, .en,
		.in_valid  (in_valid),
		.num       ({{in_item.col, {(FRAC + 1){1'b0}}}, {in_item.row, {(FRAC + 1){1'b0}}}}),
		.den       (n),
		.out_valid (scr_v),
		.quo       (scr_q)
	);

	logic                      v_s1, v_s2, v_s3;
	logic signed [SX_W-1:0]    sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic signed [2*SX_W-1:0]  sxx_s2, syy_s2;
	logic [SS_W-1:0]           ss_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= scr_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= {2'b00, scr_q[0]} - SX_W'(1 << FRAC);
			sy_s1  <= {2'b00, scr_q[1]} - SX_W'(1 << FRAC);
			sxx_s2 <= sx_s1 * sx_s1;
			syy_s2 <= sy_s1 * sy_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			ss_s3  <= SS_W'(sxx_s2) + SS_W'(syy_s2) + (SS_W'(1) << (2 * FRAC));
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
		end
	end

	// ray length
	logic              len_v;
	logic [LEN_W-1:0]  len_q;
	logic [2*SX_W-1:0] sxy_dl;
	logic [SX_W-1:0]   sx_dl, sy_dl;
	logic [SCR_W-1:0]  ax_dir, ay_dir;

	ldm_sqrt #(.NL(1), .IW(SS_W)) u_len (
		.clk, .arst_n, .en,
		.in_valid  (v_s3),
		.rad       (ss_s3),
		.out_valid (len_v),
		.root      (len_q)
	);

	ldm_delay #(.W(2 * SX_W), .DEPTH(LEN_W)) u_dl_sxy (
		.clk, .en, .d({sx_s3, sy_s3}), .q(sxy_dl)
	);

	assign sx_dl  = sxy_dl[2*SX_W-1:SX_W];
	assign sy_dl  = sxy_dl[SX_W-1:0];
	assign ax_dir = SCR_W'(sx_dl[SX_W-1] ? -sx_dl : sx_dl);
	assign ay_dir = SCR_W'(sy_dl[SX_W-1] ? -sy_dl : sy_dl);

	// unit ray direction, magnitudes
	logic                   dir_v;
	logic [2:0][U_QW-1:0]   dir_q;
	logic [1:0]             sgn_dl;

	ldm_div #(.NL(3), .NW(U_NW), .DW(LEN_W), .QW(U_QW)) u_dir (
		.clk, .arst_n, .en,
		.in_valid  (len_v),
		.num       ({U_NW'(1) << (2 * FRAC), {ay_dir, {FRAC{1'b0}}}, {ax_dir, {FRAC{1'b0}}}}),
		.den       (len_q),
		.out_valid (dir_v),
		.quo       (dir_q)
	);

	ldm_delay #(.W(2), .DEPTH(U_QW)) u_dl_sgn (
		.clk, .en, .d({sy_dl[SX_W-1], sx_dl[SX_W-1]}), .q(sgn_dl)
	);

	// closest approach and impact vector
	logic                      v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [U_W-1:0]     u_s4 [3];
	logic signed [U_W-1:0]     u_s5 [3];
	logic signed [U_W-1:0]     u_s6 [3];
	logic signed [DOT_W-1:0]   dot_s5 [3];
	logic signed [TT_W-1:0]    t_s6;
	logic signed [M_W-1:0]     m_s7 [3];
	logic signed [WORD_W-1:0]  p_s8 [3];
	logic [P_W-1:0]            sq_s9 [3];
	logic signed [WORD_W-1:0]  px_s9, py_s9, px_s10, py_s10;
	logic [P_W-1:0]            sxy_s10, sb_s10;
	logic signed [SUM_W-1:0]   dsum;
	logic signed [D_W-1:0]     diff [3];
	logic signed [WORD_W-1:0]  psat [3];

	assign dsum = SUM_W'(dot_s5[0]) + SUM_W'(dot_s5[1]) + SUM_W'(dot_s5[2]);

	for (genvar k = 0; k < 3; k++) begin : g_imp
		logic [D_W-WORD_W:0] hi;
		assign diff[k] = D_W'(tv[k]) - D_W'(m_s7[k] >>> FRAC);
		assign hi      = diff[k][D_W-1:WORD_W-1];
		// saturate to 32 bit signed
		assign psat[k] = (hi == '0 || hi == '1) ? diff[k][WORD_W-1:0]
			: (diff[k][D_W-1] ? {1'b1, {(WORD_W - 1){1'b0}}}
			: {1'b0, {(WORD_W - 1){1'b1}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s4  <= dir_v;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s4[0] <= sgn_dl[0] ? U_W'(-{1'b0, dir_q[0]}) : {1'b0, dir_q[0]};
			u_s4[1] <= sgn_dl[1] ? U_W'(-{1'b0, dir_q[1]}) : {1'b0, dir_q[1]};
			u_s4[2] <= U_W'(-{1'b0, dir_q[2]});
			for (int k = 0; k < 3; k++) begin
				dot_s5[k] <= tv[k] * u_s4[k];
				u_s5[k]   <= u_s4[k];
				u_s6[k]   <= u_s5[k];
				m_s7[k]   <= u_s6[k] * t_s6;
				p_s8[k]   <= psat[k];
				sq_s9[k]  <= p_s8[k] * p_s8[k];
			end
			t_s6    <= TT_W'(dsum >>> FRAC);
			px_s9   <= p_s8[0];
			py_s9   <= p_s8[1];
			sxy_s10 <= sq_s9[0] + sq_s9[1];
			sb_s10  <= sq_s9[0] + sq_s9[1] + sq_s9[2];
			px_s10  <= px_s9;
			py_s10  <= py_s9;
		end
	end

	// impact distance b and its x,y part
	logic                    imp_v;
	logic [1:0][IMP_W-1:0]   imp_q;
	logic [2*WORD_W-1:0]     pxy_dl;
	logic                    zero_imp;

	ldm_sqrt #(.NL(2), .IW(P_W)) u_imp (
		.clk, .arst_n, .en,
		.in_valid  (v_s10),
		.rad       ({sxy_s10, sb_s10}),
		.out_valid (imp_v),
		.root      (imp_q)
	);

	ldm_delay #(.W(2 * WORD_W), .DEPTH(IMP_W)) u_dl_pxy (
		.clk, .en, .d({px_s10, py_s10}), .q(pxy_dl)
	);

	assign zero_imp = (imp_q[0] == '0) || (imp_q[1] == '0);

	// deflection magnitude strength / b
	logic                              mag_v;
	logic [MAG_QW-1:0]                 mag_q;
	logic [2*WORD_W+IMP_W:0]           side_dl;
	logic signed [WORD_W-1:0]          px_m, py_m;
	logic [IMP_W-1:0]                  nxy_m;
	logic                              zero_m;

	ldm_div #(.NL(1), .NW(MAG_QW), .DW(IMP_W), .QW(MAG_QW)) u_mag (
		.clk, .arst_n, .en,
		.in_valid  (imp_v),
		.num       ({strength_q, {FRAC{1'b0}}}),
		.den       (imp_q[0]),
		.out_valid (mag_v),
		.quo       (mag_q)
	);

	ldm_delay #(.W(2 * WORD_W + IMP_W + 1), .DEPTH(MAG_QW)) u_dl_mag (
		.clk, .en, .d({pxy_dl, imp_q[1], zero_imp}), .q(side_dl)
	);

	assign px_m   = side_dl[2*WORD_W+IMP_W:WORD_W+IMP_W+1];
	assign py_m   = side_dl[WORD_W+IMP_W:IMP_W+1];
	assign nxy_m  = side_dl[IMP_W:1];
	assign zero_m = side_dl[0];

	// scale mag * |p| / |(px,py)|
	logic                 v_s11, v_s12, v_s13;
	logic [WORD_W-1:0]    a_m [2];
	logic [PP_W-1:0]      lo_s11 [2];
	logic [PP_W-1:0]      hi_s11 [2];
	logic [PR_W-1:0]      pr_s12 [2];
	logic [1:0]           ovf_c;
	logic [1:0]           ovf_s13;
	logic [1:0][P_W-1:0]  num_s13;
	logic [1:0]           sgn_s11, sgn_s12, sgn_s13;
	logic [IMP_W-1:0]     nxy_s11, nxy_s12, nxy_s13;
	logic                 zero_s11, zero_s12, zero_s13;

	assign a_m[0] = px_m[WORD_W-1] ? -px_m : px_m;
	assign a_m[1] = py_m[WORD_W-1] ? -py_m : py_m;

	for (genvar k = 0; k < 2; k++) begin : g_ovf
		assign ovf_c[k] = pr_s12[k] >= PR_W'({nxy_s12, {WORD_W{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s11 <= mag_v;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				lo_s11[k]  <= mag_q[HALF-1:0] * a_m[k];
				hi_s11[k]  <= mag_q[MAG_QW-1:HALF] * a_m[k];
				pr_s12[k]  <= {hi_s11[k], {HALF{1'b0}}} + PR_W'(lo_s11[k]);
				num_s13[k] <= ovf_c[k] ? '0 : pr_s12[k][P_W-1:0];
			end
			sgn_s11  <= {py_m[WORD_W-1], px_m[WORD_W-1]};
			sgn_s12  <= sgn_s11;
			sgn_s13  <= sgn_s12;
			ovf_s13  <= ovf_c;
			nxy_s11  <= nxy_m;
			nxy_s12  <= nxy_s11;
			nxy_s13  <= nxy_s12;
			zero_s11 <= zero_m;
			zero_s12 <= zero_s11;
			zero_s13 <= zero_s12;
		end
	end

	logic                   scl_v;
	logic [1:0][WORD_W-1:0] scl_q;
	logic [4:0]             flg_dl;

	ldm_div #(.NL(2), .NW(P_W), .DW(IMP_W), .QW(WORD_W)) u_scl (
		.clk, .arst_n, .en,
		.in_valid  (v_s13),
		.num       (num_s13),
		.den       (nxy_s13),
		.out_valid (scl_v),
		.quo       (scl_q)
	);

	ldm_delay #(.W(5), .DEPTH(WORD_W)) u_dl_flg (
		.clk, .en, .d({sgn_s13, ovf_s13, zero_s13}), .q(flg_dl)
	);

	// signed, saturated deflection and magnification divisor
	logic                     v_s14, v_s15;
	logic signed [WORD_W-1:0] d_s14 [2];
	logic signed [WORD_W-1:0] d_s15 [2];
	logic [WORD_W-1:0]        dsat [2];
	logic signed [J_W-1:0]    jsum;
	logic [J_W-1:0]           jabs;
	logic [J_W-1:0]           j_s15;

	for (genvar k = 0; k < 2; k++) begin : g_defl
		logic big;
		assign big = flg_dl[1+k] || scl_q[k][WORD_W-1];
		always_comb begin
			if (flg_dl[0]) begin
				dsat[k] = '0;
			end else if (flg_dl[3+k]) begin
				dsat[k] = big ? {1'b1, {(WORD_W - 1){1'b0}}} : -scl_q[k];
			end else begin
				dsat[k] = big ? {1'b0, {(WORD_W - 1){1'b1}}} : scl_q[k];
			end
		end
	end

	assign jsum = J_W'(1 << FRAC) + J_W'(d_s14[0]) + J_W'(d_s14[1]);
	assign jabs = jsum[J_W-1] ? -jsum : jsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s14 <= scl_v;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				d_s14[k] <= dsat[k];
				d_s15[k] <= d_s14[k];
			end
			j_s15 <= (jabs < J_W'(J_FLOOR)) ? J_W'(J_FLOOR) : jabs;
		end
	end

	logic                amp_v;
	logic [MAG_W-1:0]    amp_q;
	logic [2*WORD_W-1:0] dd_dl;

	ldm_div #(.NL(1), .NW(AMP_NW), .DW(J_W), .QW(MAG_W)) u_amp (
		.clk, .arst_n, .en,
		.in_valid  (v_s15),
		.num       (AMP_NW'(1) << (2 * FRAC)),
		.den       (j_s15),
		.out_valid (amp_v),
		.quo       (amp_q)
	);

	ldm_delay #(.W(2 * WORD_W), .DEPTH(MAG_W)) u_dl_dd (
		.clk, .en, .d({d_s15[0], d_s15[1]}), .q(dd_dl)
	);

	// output register; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= amp_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.deflect_x     <= dd_dl[2*WORD_W-1:WORD_W];
			out_item.deflect_y     <= dd_dl[WORD_W-1:0];
			out_item.magnification <= (amp_q > MAG_CAP) ? MAG_CAP : amp_q;
		end
	end

endmodule
`default_nettype wire

// ===== tb/ldm_deflection_checker.sv =====
`timescale 1ns / 100ps
module ldm_deflection_checker
	import ldm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ldm_in_t              in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ldm_out_t             out_item,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	output int                   errors,
	output int                   awaiting
);

	// shadow copy of the write-port registers
	longint          hole_x, hole_y, hole_z;
	longint          cam_x, cam_y, cam_z;
	longint unsigned strength;
	longint unsigned grid;

	ldm_out_t expected_points[$];

	assign awaiting = expected_points.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint quot_toward_zero(longint num, longint unsigned den);
		longint unsigned a;
		a = (num < 0) ? -num : num;
		return (num < 0) ? -$signed(a / den) : $signed(a / den);
	endfunction

	function automatic longint screen(logic [IDX_W-1:0] idx, longint unsigned n);
		longint unsigned num;
		num = (64'(idx) * 2) << FRAC;
		return clip32($signed(num / n) - 64'sd65536);
	endfunction

	// floor(mag*|p|/den) carrying the sign of p, clipped to 2^40 then 32 bits
	function automatic longint scaled(longint unsigned mag, longint p, longint unsigned den);
		longint unsigned a, q;
		logic [127:0]    prod;
		a = (p < 0) ? -p : p;
		prod = {64'd0, mag} * {64'd0, a};
		if (prod > 128'hFFFF_FFFF_FFFF_FFFF)
			q = 64'd1 << 40;
		else
			q = prod[63:0] / den;
		if (q > (64'd1 << 40))
			q = 64'd1 << 40;
		return clip32((p < 0) ? -$signed(q) : $signed(q));
	endfunction

	function automatic ldm_out_t deflection_at(ldm_in_t pt);
		longint unsigned n, ss, len, sxy, b, nxy, mag, j, m;
		longint          sx, sy, ux, uy, uz, tx, ty, tz, t, px, py, pz, dx, dy, sum;
		ldm_out_t        r;
		n = (grid == 0) ? 1 : grid;
		sx = screen(pt.row, n);
		sy = screen(pt.col, n);
		ss = sx * sx + sy * sy + 64'h1_0000_0000;
		len = root(ss);
		ux = quot_toward_zero(sx * 64'sd65536, len);
		uy = quot_toward_zero(sy * 64'sd65536, len);
		uz = -$signed(64'h1_0000_0000 / len);
		tx = hole_x - cam_x;
		ty = hole_y - cam_y;
		tz = hole_z - cam_z;
		t = (tx * ux + ty * uy + tz * uz) >>> FRAC;
		px = clip32(tx - ((ux * t) >>> FRAC));
		py = clip32(ty - ((uy * t) >>> FRAC));
		pz = clip32(tz - ((uz * t) >>> FRAC));
		sxy = px * px + py * py;
		b = root(sxy + pz * pz);
		nxy = root(sxy);
		dx = 0;
		dy = 0;
		if (b != 0 && nxy != 0) begin
			mag = (strength << FRAC) / b;
			dx = scaled(mag, px, nxy);
			dy = scaled(mag, py, nxy);
		end
		sum = 64'sd65536 + dx + dy;
		j = (sum < 0) ? -sum : sum;
		if (j < J_FLOOR)
			j = J_FLOOR;
		m = 64'h1_0000_0000 / j;
		if (m > MAG_CAP)
			m = MAG_CAP;
		r.deflect_x = dx[31:0];
		r.deflect_y = dy[31:0];
		r.magnification = m[MAG_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ldm_out_t want;
		int       bad;
		if (!arst_n) begin
			hole_x <= 0;
			hole_y <= 0;
			hole_z <= 0;
			cam_x <= 0;
			cam_y <= 0;
			cam_z <= 0;
			strength <= 0;
			grid <= GRID_RESET;
			errors <= 0;
		end else begin
			bad = 0;
			if (wr_en) begin
				case (ldm_reg_t'(wr_index))
				REG_HOLE_X:        hole_x <= $signed(wr_data);
				REG_HOLE_Y:        hole_y <= $signed(wr_data);
				REG_HOLE_Z:        hole_z <= $signed(wr_data);
				REG_CAMERA_X:      cam_x <= $signed(wr_data);
				REG_CAMERA_Y:      cam_y <= $signed(wr_data);
				REG_CAMERA_Z:      cam_z <= $signed(wr_data);
				REG_LENS_STRENGTH: strength <= wr_data;
				REG_GRID_SIZE:     grid <= wr_data[GRID_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_points = {expected_points, deflection_at(in_item)};
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected result transfer %h", out_item);
					bad++;
				end else begin
					want = expected_points.pop_front();
					if (out_item.deflect_x !== want.deflect_x) begin
						$error("deflect_x expected %h got %h", want.deflect_x,
							out_item.deflect_x);
						bad++;
					end
					if (out_item.deflect_y !== want.deflect_y) begin
						$error("deflect_y expected %h got %h", want.deflect_y,
							out_item.deflect_y);
						bad++;
					end
					if (out_item.magnification !== want.magnification) begin
						$error("magnification expected %h got %h", want.magnification,
							out_item.magnification);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

// ===== tb/tb_lensing_deflection_map.sv =====
`timescale 1ns / 100ps
module tb_lensing_deflection_map;
	import ldm_pkg::*;

	localparam int LATENCY = 230;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	ldm_in_t              in_item;
	logic                 out_valid;
	logic                 out_ready;
	ldm_out_t             out_item;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [WORD_W-1:0]    wr_data;
	int                   errors;
	int                   awaiting;

	logic                 long_hold_go;
	int                   burst_left;
	bit                   no_gaps;
	int                   grid_now;

	lensing_deflection_map u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	ldm_deflection_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.errors    (errors),
		.awaiting  (awaiting)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("tb_lensing_deflection_map: errors");
		$finish;
	end

	// receiver: ready pattern redrawn at random, one long hold-off on request
	initial begin
		int  mode;
		int  cyc;
		int  hold;
		bit  held;
		out_ready = 1'b0;
		mode = 0;
		cyc = 0;
		held = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (long_hold_go && !held) begin
				held = 1;
				out_ready <= 1'b0;
				for (hold = 0; hold < 3 * LATENCY; hold++)
					@(negedge clk);
			end
			case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic drain();
		while (awaiting != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic configure(longint hx, longint hy, longint hz, longint cx, longint cy,
		longint cz, longint unsigned s, int g);
		drain();
		wr_en <= 1'b1;
		wr_index <= REG_HOLE_X;        wr_data <= hx[31:0]; @(negedge clk);
		wr_index <= REG_HOLE_Y;        wr_data <= hy[31:0]; @(negedge clk);
		wr_index <= REG_HOLE_Z;        wr_data <= hz[31:0]; @(negedge clk);
		wr_index <= REG_CAMERA_X;      wr_data <= cx[31:0]; @(negedge clk);
		wr_index <= REG_CAMERA_Y;      wr_data <= cy[31:0]; @(negedge clk);
		wr_index <= REG_CAMERA_Z;      wr_data <= cz[31:0]; @(negedge clk);
		wr_index <= REG_LENS_STRENGTH; wr_data <= s[31:0];  @(negedge clk);
		wr_index <= REG_GRID_SIZE;     wr_data <= WORD_W'(g); @(negedge clk);
		wr_en <= 1'b0;
		grid_now = g;
	endtask

	// offer one point; returns at the falling edge after its transfer
	task automatic send_point(int r, int c);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_item.row <= r[IDX_W-1:0];
		in_item.col <= c[IDX_W-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic corners_and_center();
		int h;
		h = (grid_now == 0) ? 0 : grid_now / 2;
		send_point(0, 0);
		send_point(4095, 4095);
		send_point(0, 4095);
		send_point(4095, 0);
		send_point(h, h);
		send_point(h, 0);
		in_valid <= 1'b0;
	endtask

	function automatic longint pick_coord();
		if ($urandom_range(0, 3) == 0)
			return $signed($urandom());
		return longint'($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
	endfunction

	task automatic random_phase(int count);
		longint unsigned s;
		int              g;
		int              lim;
		int              r;
		int              c;
		case ($urandom_range(0, 5))
		0: g = 1;
		1: g = 2 + $urandom_range(0, 14);
		2: g = 512;
		3: g = 4096;
		4: g = $urandom_range(1, 4096);
		default: g = $urandom_range(0, 8191);
		endcase
		s = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 2 << FRAC);
		configure(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			pick_coord(), s, g);
		no_gaps = ($urandom_range(0, 3) == 0);
		lim = (g == 0) ? 1 : ((g > 4096) ? 4096 : g);
		repeat (count) begin
			if ($urandom_range(0, 9) < 8) begin
				r = $urandom_range(0, lim - 1);
				c = $urandom_range(0, lim - 1);
			end else begin
				r = $urandom_range(0, 4095);
				c = $urandom_range(0, 4095);
			end
			send_point(r, c);
			if (!long_hold_go && $urandom_range(0, 3) == 0)
				long_hold_go <= 1'b1;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		wr_en = 1'b0;
		wr_index = REG_HOLE_X;
		wr_data = '0;
		long_hold_go = 1'b0;
		burst_left = 0;
		no_gaps = 0;
		grid_now = GRID_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// zero strength at reset values; hole on the camera gives zero impact
		corners_and_center();
		// hole straight ahead: center ray has zero impact
		configure(0, 0, -(5 << FRAC), 0, 0, 0, 1 << FRAC, 512);
		corners_and_center();
		// huge impact, full strength
		configure(64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
			-64'sd2147483648, 64'sd2147483647, 64'hFFFF_FFFF, 4096);
		corners_and_center();
		configure(-64'sd2147483648, 3 << FRAC, 64'sd2147483647, 1 << FRAC, 0, 0,
			1 << (FRAC - 2), 0);
		corners_and_center();
		configure(1 << (FRAC - 3), -(1 << (FRAC - 3)), -(2 << FRAC), 0, 0, 0,
			1 << (FRAC - 1), 8191);
		corners_and_center();
		repeat (9)
			random_phase(125);
		while (awaiting != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0)
			$display("tb_lensing_deflection_map: clean");
		else
			$display("tb_lensing_deflection_map: errors");
		$finish;
	end

endmodule
